// ----- design/u8sd_pkg.sv -----
`default_nettype none

package u8sd_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned CP_W      = 21;
   localparam int unsigned STATUS_W  = 3;
   // widest partial value before the last trail: 3 lead bits plus two trails
   localparam int unsigned PARTIAL_W = 15;

   localparam logic [1:0]      TRAIL_TAG   = 2'b10;
   localparam logic [CP_W-1:0] RANGE_LIMIT = 21'h000110;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_BAD_LEAD  = 3'd1,
      ST_BAD_TRAIL = 3'd2,
      ST_RANGE     = 3'd3,
      ST_TRUNC     = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]           trail_left;
      logic                 first_pending;
      logic [PARTIAL_W-1:0] partial;
   } dec_state_type;

   typedef struct packed {
      logic                 emit;
      logic [CP_W-1:0]      code_point;
      status_type           status;
   } dec_result_type;

   localparam dec_state_type IDLE_STATE = '{
      trail_left: 2'd0, first_pending: 1'b0, partial: '0};

endpackage

`default_nettype wire

// ----- design/u8sd_if.sv -----
`default_nettype none

interface u8sd_req_if;
   import u8sd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              end_of_buffer;

   modport source (output valid, output in_byte, output end_of_buffer, input ready);
   modport sink   (input valid, input in_byte, input end_of_buffer, output ready);
endinterface

interface u8sd_rsp_if;
   import u8sd_pkg::*;

   logic                valid;
   logic                ready;
   logic [CP_W-1:0]     code_point;
   logic [STATUS_W-1:0] status;
   logic                buffer_end;

   modport source (output valid, output code_point, output status, output buffer_end,
                   input ready);
   modport sink   (input valid, input code_point, input status, input buffer_end,
                   output ready);
endinterface

`default_nettype wire

// ----- design/u8sd_step.sv -----
`default_nettype none

module u8sd_step (
   input  u8sd_pkg::dec_state_type       state,
   input  logic [u8sd_pkg::BYTE_W-1:0]   in_byte,
   input  logic                          end_of_buffer,
   output u8sd_pkg::dec_state_type       state_next,
   output u8sd_pkg::dec_result_type      result
);
   import u8sd_pkg::*;

   logic [CP_W-1:0] merged;

   assign merged = {state.partial, in_byte[5:0]};

   always_comb begin
      state_next        = IDLE_STATE;
      result.emit       = 1'b0;
      result.code_point = '0;
      result.status     = ST_OK;

      if (state.trail_left == 2'd0) begin
         priority if (!in_byte[7]) begin
            result.emit       = 1'b1;
            result.code_point = {{(CP_W-BYTE_W){1'b0}}, in_byte};
         end else if (!in_byte[6] || in_byte[7:3] == 5'b11111) begin
            result.emit   = 1'b1;
            result.status = ST_BAD_LEAD;
         end else if (end_of_buffer) begin
            result.emit   = 1'b1;
            result.status = ST_TRUNC;
         end else if (!in_byte[5]) begin
            state_next.trail_left = 2'd1;
            state_next.partial    = {{(PARTIAL_W-5){1'b0}}, in_byte[4:0]};
         end else if (!in_byte[4]) begin
            state_next.trail_left = 2'd2;
            state_next.partial    = {{(PARTIAL_W-4){1'b0}}, in_byte[3:0]};
         end else begin
            state_next.trail_left    = 2'd3;
            state_next.first_pending = 1'b1;
            state_next.partial       = {{(PARTIAL_W-3){1'b0}}, in_byte[2:0]};
         end
      end else begin
         priority if (end_of_buffer && state.trail_left != 2'd1) begin
            result.emit   = 1'b1;
            result.status = ST_TRUNC;
         end else if (in_byte[7:6] != TRAIL_TAG) begin
            result.emit   = 1'b1;
            result.status = ST_BAD_TRAIL;
         end else if (state.first_pending && merged >= RANGE_LIMIT) begin
            result.emit   = 1'b1;
            result.status = ST_RANGE;
         end else if (state.trail_left == 2'd1) begin
            result.emit       = 1'b1;
            result.code_point = merged;
         end else begin
            state_next.trail_left = state.trail_left - 2'd1;
            state_next.partial    = merged[PARTIAL_W-1:0];
         end
      end
   end

endmodule

`default_nettype wire

// ----- design/utf8_stream_decoder_unit.sv -----
// UTF-8 stream decoder.
// req_ch carries one raw byte per request plus an end-of-buffer flag; rsp_ch
// returns one code point with a status code for every finished sequence,
// and one error result for a bad lead, bad trail, out-of-range value or a
// sequence cut off by the end of the buffer. Lead bytes and inner trail
// bytes produce no result.
// One byte is taken every cycle unless a result stalls. The sequence state
// and the decode of the incoming byte sit in front of a single result
// register, so a result appears on rsp_ch in the cycle after its last byte.
// req_ch.ready is high when the result register is empty or is being
// drained in the same cycle; while the receiver holds rsp_ch.ready low with
// a result waiting, the result holds and no byte is taken.
// A synchronous reset empties the result register and returns the decoder
// to idle, between sequences. After an error the partial sequence and the
// offending byte are dropped and decoding restarts at the next byte.
`default_nettype none

module utf8_stream_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   u8sd_req_if.sink   req_ch,
   u8sd_rsp_if.source rsp_ch
);
   import u8sd_pkg::*;

   dec_state_type       state_ff, state_in;
   dec_state_type       step_state;
   dec_result_type      step_result;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CP_W-1:0]     code_point_ff;
   logic [STATUS_W-1:0] status_ff;
   logic                buffer_end_ff;
   logic                accept;

   u8sd_step step (
      .state         (state_ff),
      .in_byte       (req_ch.in_byte),
      .end_of_buffer (req_ch.end_of_buffer),
      .state_next    (step_state),
      .result        (step_result)
   );

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      state_in     = accept ? step_state : state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (accept && step_result.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE_STATE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && step_result.emit) begin
         code_point_ff <= step_result.code_point;
         status_ff     <= step_result.status;
         buffer_end_ff <= req_ch.end_of_buffer;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.code_point = code_point_ff;
   assign rsp_ch.status     = status_ff;
   assign rsp_ch.buffer_end = buffer_end_ff;

endmodule

`default_nettype wire

// ----- design/u8sd_checker.sv -----
`default_nettype none

module u8sd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [u8sd_pkg::CP_W-1:0]     rsp_code_point,
   input logic [u8sd_pkg::STATUS_W-1:0] rsp_status
);
   import u8sd_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code_point)
                                  && $stable(rsp_status))
      else $error("stalled result changed or dropped");

   // single result slot: a stalled result blocks new requests
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while result slot is full");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_code_point == '0)
      else $error("error result carries a nonzero code point");

   a_free_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused with empty result slot");

endmodule

bind utf8_stream_decoder_unit u8sd_checker checker_inst (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_code_point (rsp_ch.code_point),
   .rsp_status     (rsp_ch.status)
);

`default_nettype wire
